FILE: hdl/lsbse_pkg.sv
// ----------------------------------------------------------------------------
// LSB steganography package
// Shared types and codes for the embed/extract datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package lsbse_pkg;

	localparam int PIX_W = 8;
	localparam int LEN_W = 32;

	localparam logic [1:0] REG_BITS_MODE  = 2'd0;
	localparam logic [1:0] REG_DIRECTION  = 2'd1;
	localparam logic [1:0] REG_MSG_LENGTH = 2'd2;

	localparam logic [1:0] BM_ONE = 2'd0;
	localparam logic [1:0] BM_TWO = 2'd1;

	localparam logic DIR_EMBED   = 1'b0;
	localparam logic DIR_EXTRACT = 1'b1;

	typedef enum logic [2:0] {
		PH_HEAD = 3'b001,
		PH_MSG  = 3'b010,
		PH_DONE = 3'b100
	} phase_t;

	typedef struct packed {
		logic [1:0]       bits_mode;
		logic             direction;
		logic [LEN_W-1:0] message_length;
	} cfg_t;

	typedef struct packed {
		logic [PIX_W-1:0] pixel_out;
		logic             byte_taken;
		logic [7:0]       byte_out;
		logic             byte_valid;
		logic [LEN_W-1:0] length_out;
		logic             length_valid;
		logic             done_res;
		logic             error;
	} res_t;

endpackage

`default_nettype wire

FILE: hdl/lsb_stego_embed_extract.sv
// ----------------------------------------------------------------------------
// LSB steganography embed and extract
// Pixel stream block that hides or recovers a length-prefixed message in
// the low bits of 8-bit gray pixels.
// ----------------------------------------------------------------------------
// One pixel is accepted per clock while the result side is not stalled. Each
// pixel passes through the input register and then the result register, and a
// steady stream runs at one pixel per cycle while out_ready stays high. The
// four-bit step chain in lsbse_step sits between
// the input register and the result register and also updates the header
// and message state. The result register decouples the two sides, so a new
// pixel is taken while an earlier result waits. Configuration should be
// written only while no pixel is in flight.
`default_nettype none

module lsb_stego_embed_extract #(
	parameter int HEADER_BITS = 32
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        cfg_we,
	input  wire logic [1:0]                  cfg_index,
	input  wire logic [lsbse_pkg::LEN_W-1:0] cfg_data,
	input  wire logic                        in_valid,
	output logic                             in_ready,
	input  wire logic [lsbse_pkg::PIX_W-1:0] pixel_in,
	input  wire logic [7:0]                  msg_byte,
	input  wire logic                        frame_start,
	output logic                             out_valid,
	input  wire logic                        out_ready,
	output logic [lsbse_pkg::PIX_W-1:0]      pixel_out,
	output logic                             byte_taken,
	output logic [7:0]                       byte_out,
	output logic                             byte_valid,
	output logic [lsbse_pkg::LEN_W-1:0]      length_out,
	output logic                             length_valid,
	output logic                             done_res,
	output logic                             error
);
	import lsbse_pkg::*;

	localparam int CW = $clog2(HEADER_BITS);

	cfg_t             cfg;
	logic             valid_s1;
	logic [PIX_W-1:0] pixel_s1;
	logic [7:0]       mb_s1;
	logic             fs_s1;
	logic             valid_s2;
	res_t             res_s2;
	res_t             res_nxt;
	logic             advance;

	phase_t           phase_q;
	logic [CW-1:0]    bit_count_q;
	logic [LEN_W-1:0] shift_bits_q;
	logic [LEN_W-1:0] byte_count_q;
	logic [LEN_W-1:0] length_q;
	phase_t           phase_nxt;
	logic [CW-1:0]    bit_count_nxt;
	logic [LEN_W-1:0] shift_bits_nxt;
	logic [LEN_W-1:0] byte_count_nxt;
	logic [LEN_W-1:0] length_nxt;

	lsbse_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	lsbse_step #(
		.HEADER_BITS (HEADER_BITS)
	) u_step (
		.cfg            (cfg),
		.pixel          (pixel_s1),
		.mb             (mb_s1),
		.frame_start    (fs_s1),
		.phase          (phase_q),
		.bit_count      (bit_count_q),
		.shift_bits     (shift_bits_q),
		.byte_count     (byte_count_q),
		.length         (length_q),
		.nxt_phase      (phase_nxt),
		.nxt_bit_count  (bit_count_nxt),
		.nxt_shift_bits (shift_bits_nxt),
		.nxt_byte_count (byte_count_nxt),
		.nxt_length     (length_nxt),
		.res            (res_nxt)
	);

	assign advance  = valid_s1 && (!valid_s2 || out_ready);
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			pixel_s1 <= pixel_in;
			mb_s1    <= msg_byte;
			fs_s1    <= frame_start;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (out_ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_s2 <= res_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= PH_HEAD;
			bit_count_q  <= '0;
			shift_bits_q <= '0;
			byte_count_q <= '0;
			length_q     <= '0;
		end else if (advance) begin
			phase_q      <= phase_nxt;
			bit_count_q  <= bit_count_nxt;
			shift_bits_q <= shift_bits_nxt;
			byte_count_q <= byte_count_nxt;
			length_q     <= length_nxt;
		end
	end

	assign out_valid    = valid_s2;
	assign pixel_out    = res_s2.pixel_out;
	assign byte_taken   = res_s2.byte_taken;
	assign byte_out     = res_s2.byte_out;
	assign byte_valid   = res_s2.byte_valid;
	assign length_out   = res_s2.length_out;
	assign length_valid = res_s2.length_valid;
	assign done_res     = res_s2.done_res;
	assign error        = res_s2.error;

endmodule

`default_nettype wire

FILE: hdl/lsbse_cfg.sv
// ----------------------------------------------------------------------------
// LSB steganography configuration registers
// Decodes the write port into the mode, direction and length registers.
// ----------------------------------------------------------------------------
`default_nettype none

module lsbse_cfg (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        cfg_we,
	input  wire logic [1:0]                  cfg_index,
	input  wire logic [lsbse_pkg::LEN_W-1:0] cfg_data,
	output lsbse_pkg::cfg_t                  cfg
);
	import lsbse_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_BITS_MODE:  cfg_q.bits_mode <= cfg_data[1:0];
				REG_DIRECTION:  cfg_q.direction <= cfg_data[0];
				REG_MSG_LENGTH: cfg_q.message_length <= cfg_data;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

`default_nettype wire

FILE: hdl/lsbse_step.sv
// ----------------------------------------------------------------------------
// LSB steganography pixel step
// Handles the one, two or four low bits of a pixel in order, updating the
// header and message state and forming the result for that pixel.
// ----------------------------------------------------------------------------
`default_nettype none

module lsbse_step #(
	parameter int HEADER_BITS = 32
) (
	input  wire lsbse_pkg::cfg_t              cfg,
	input  wire logic [lsbse_pkg::PIX_W-1:0]  pixel,
	input  wire logic [7:0]                   mb,
	input  wire logic                         frame_start,
	input  wire lsbse_pkg::phase_t            phase,
	input  wire logic [$clog2(HEADER_BITS)-1:0] bit_count,
	input  wire logic [lsbse_pkg::LEN_W-1:0]  shift_bits,
	input  wire logic [lsbse_pkg::LEN_W-1:0]  byte_count,
	input  wire logic [lsbse_pkg::LEN_W-1:0]  length,
	output lsbse_pkg::phase_t                 nxt_phase,
	output logic [$clog2(HEADER_BITS)-1:0]    nxt_bit_count,
	output logic [lsbse_pkg::LEN_W-1:0]       nxt_shift_bits,
	output logic [lsbse_pkg::LEN_W-1:0]       nxt_byte_count,
	output logic [lsbse_pkg::LEN_W-1:0]       nxt_length,
	output lsbse_pkg::res_t                   res
);
	import lsbse_pkg::*;

	localparam int CW = $clog2(HEADER_BITS);

	phase_t             ph;
	logic [CW-1:0]      bc;
	logic [CW:0]        bc_inc;
	logic [CW-1:0]      hdr_idx;
	logic [LEN_W-1:0]   sb;
	logic [LEN_W-1:0]   bcnt;
	logic [LEN_W-1:0]   len;
	logic [LEN_W-1:0]   byte_inc;
	logic               last_byte;
	logic [HEADER_BITS-1:0] hdr;
	logic [7:0]         cur_byte;
	logic [2:0]         nbits;
	logic [1:0]         pos;
	logic [3:0]         low;
	logic               b;
	logic               extract;
	logic               taken;
	logic               bv;
	logic [7:0]         bo;
	logic               lv;
	logic [LEN_W-1:0]   lo;
	logic               done;

	always_comb begin
		unique case (cfg.bits_mode)
			BM_ONE:  nbits = 3'd1;
			BM_TWO:  nbits = 3'd2;
			default: nbits = 3'd4;
		endcase
	end

	always_comb begin
		extract  = (cfg.direction == DIR_EXTRACT);
		ph       = phase;
		bc       = bit_count;
		sb       = shift_bits;
		bcnt     = byte_count;
		len      = length;
		taken    = 1'b0;
		bv       = 1'b0;
		bo       = '0;
		lv       = 1'b0;
		lo       = '0;
		low      = pixel[3:0];
		hdr      = '0;
		hdr_idx  = '0;
		bc_inc   = '0;
		cur_byte = '0;
		pos      = '0;
		b        = 1'b0;
		if (frame_start) begin
			ph   = PH_HEAD;
			bc   = '0;
			sb   = '0;
			bcnt = '0;
			len  = '0;
		end
		// A byte can only complete in a pixel that started in the message phase.
		byte_inc  = bcnt + LEN_W'(1);
		last_byte = (byte_inc == len);
		for (int i = 0; i < 4; i++) begin
			if (i < int'(nbits)) begin
				pos    = 2'(int'(nbits) - 1 - i);
				b      = pixel[pos];
				bc_inc = {1'b0, bc} + (CW+1)'(1);
				case (ph)
					PH_HEAD: begin
						if (!extract && bc == '0) begin
							len = cfg.message_length;
						end
						if (extract) begin
							sb = {sb[LEN_W-2:0], b};
						end else begin
							hdr     = HEADER_BITS'(len);
							hdr_idx = CW'(HEADER_BITS - 1) - bc;
							b       = hdr[hdr_idx];
						end
						if (bc_inc >= (CW+1)'(HEADER_BITS)) begin
							bc = '0;
							if (extract) begin
								len = sb;
								lo  = sb;
								lv  = 1'b1;
							end
							sb   = '0;
							bcnt = '0;
							ph   = (len == '0) ? PH_DONE : PH_MSG;
						end else begin
							bc = bc_inc[CW-1:0];
						end
					end
					PH_MSG: begin
						if (extract) begin
							sb = {24'd0, sb[6:0], b};
						end else begin
							if (bc == '0) begin
								sb    = {24'd0, mb};
								taken = 1'b1;
							end
							cur_byte = sb[7:0];
							b        = cur_byte[3'd7 - bc[2:0]];
						end
						if (bc[2:0] == 3'd7) begin
							bc = '0;
							if (extract) begin
								bo = sb[7:0];
								bv = 1'b1;
							end
							bcnt = byte_inc;
							if (last_byte) begin
								ph = PH_DONE;
							end
						end else begin
							bc = bc_inc[CW-1:0];
						end
					end
					default: ;
				endcase
				low[pos] = b;
			end
		end
		done = (ph != PH_HEAD) && (ph != PH_MSG);
	end

	assign nxt_phase      = ph;
	assign nxt_bit_count  = bc;
	assign nxt_shift_bits = sb;
	assign nxt_byte_count = bcnt;
	assign nxt_length     = len;

	assign res.pixel_out    = {pixel[PIX_W-1:4], low};
	assign res.byte_taken   = taken;
	assign res.byte_out     = bo;
	assign res.byte_valid   = bv;
	assign res.length_out   = lo;
	assign res.length_valid = lv;
	assign res.done_res     = done;
	assign res.error        = done && (len == '0);

endmodule

`default_nettype wire

FILE: hdl/lsbse_checker.sv
// ----------------------------------------------------------------------------
// LSB steganography port checker
// Watches the result channel of the top level over time.
// ----------------------------------------------------------------------------
`default_nettype none

module lsbse_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        out_valid,
	input wire logic        out_ready,
	input wire logic [7:0]  pixel_out,
	input wire logic        byte_taken,
	input wire logic        byte_valid,
	input wire logic        length_valid,
	input wire logic        done_res,
	input wire logic        error
);

	// A stalled result keeps its request and its pixel.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(pixel_out))
		else $error("result request dropped or changed while stalled");

	// The length header and a message byte never finish on the same pixel.
	a_len_byte: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(byte_valid && length_valid))
		else $error("length and byte completed together");

	// Embedding and extracting results never mix in one request.
	a_dir_mix: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && byte_taken |-> !byte_valid && !length_valid)
		else $error("embed and extract flags raised together");

	// An error is only reported once the frame is finished.
	a_err_done: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && error |-> done_res)
		else $error("error raised before the frame finished");

endmodule

bind lsb_stego_embed_extract lsbse_checker u_lsbse_checker (.*);

`default_nettype wire

FILE: dv/lsb_stego_embed_extract_tb.sv
// ----------------------------------------------------------------------------
// LSB steganography embed/extract testbench
// Drives pixel requests through the valid/ready pipe with random idling on
// both sides. Each result is checked against a cycle-free predictor of the
// header and message state, or a fixed result for some rows. A short directed
// table comes first, then random frames mostly well formed in both directions.
// ----------------------------------------------------------------------------
`default_nettype none

module lsb_stego_embed_extract_tb;

	import lsbse_pkg::*;

	localparam logic [1:0] BM_FOUR = 2'd2;
	localparam logic [1:0] BM_RSVD = 2'd3;

	typedef struct packed {
		logic             is_cfg;
		logic [1:0]       idx;
		logic [LEN_W-1:0] val;
		logic [PIX_W-1:0] pix;
		logic [7:0]       msg;
		logic             fs;
		logic             typed;
		res_t             exp;
	} step_row_t;

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             cfg_we = 1'b0;
	logic [1:0]       cfg_index = REG_BITS_MODE;
	logic [LEN_W-1:0] cfg_data = '0;
	logic             in_valid = 1'b0;
	logic             in_ready;
	logic [PIX_W-1:0] pixel_in = '0;
	logic [7:0]       msg_byte = '0;
	logic             frame_start = 1'b0;
	logic             out_valid;
	logic             out_ready = 1'b0;
	logic [PIX_W-1:0] pixel_out;
	logic             byte_taken;
	logic [7:0]       byte_out;
	logic             byte_valid;
	logic [LEN_W-1:0] length_out;
	logic             length_valid;
	logic             done_res;
	logic             error;

	// Register shadow and frame state of the predictor.
	logic [1:0]       cfg_mode = BM_ONE;
	logic             cfg_dir = DIR_EMBED;
	logic [LEN_W-1:0] cfg_len = '0;
	phase_t           st_phase = PH_HEAD;
	int unsigned      st_bits = 0;
	logic [31:0]      st_shift = '0;
	logic [31:0]      st_bytes = '0;
	logic [31:0]      st_len = '0;

	res_t      pending[$];
	step_row_t dir_tab[$];
	int        mismatches = 0;
	int        items_sent = 0;
	int        results_seen = 0;
	int        frames = 0;
	int        lengths_seen = 0;
	int        bytes_recovered = 0;
	int        bytes_embedded = 0;
	int        zero_flags = 0;

	lsb_stego_embed_extract DUT (.*);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic res_t stego_predict(logic [7:0] pix, logic [7:0] msg, logic fs);
		res_t        r;
		int unsigned n;
		logic [7:0]  repl;
		logic [7:0]  lowmask;
		logic        b;
		r = '0;
		repl = '0;
		n = (cfg_mode == BM_ONE) ? 1 : (cfg_mode == BM_TWO) ? 2 : 4;
		lowmask = 8'((1 << n) - 1);
		if (fs) begin
			st_phase = PH_HEAD;
			st_bits = 0;
			st_shift = '0;
			st_bytes = '0;
			st_len = '0;
		end
		for (int i = 0; i < n; i++) begin
			b = pix[n - 1 - i];
			case (st_phase)
			PH_HEAD: begin
				if (cfg_dir == DIR_EMBED && st_bits == 0)
					st_len = cfg_len;
				if (cfg_dir == DIR_EXTRACT)
					st_shift = {st_shift[30:0], b};
				else
					b = st_len[31 - st_bits];
				st_bits++;
				if (st_bits == 32) begin
					st_bits = 0;
					if (cfg_dir == DIR_EXTRACT) begin
						st_len = st_shift;
						r.length_out = st_shift;
						r.length_valid = 1'b1;
					end
					st_shift = '0;
					st_bytes = '0;
					st_phase = (st_len == 0) ? PH_DONE : PH_MSG;
				end
			end
			PH_MSG: begin
				if (cfg_dir == DIR_EXTRACT) begin
					st_shift = {24'd0, st_shift[6:0], b};
				end else begin
					if (st_bits == 0) begin
						st_shift = {24'd0, msg};
						r.byte_taken = 1'b1;
					end
					b = st_shift[7 - st_bits];
				end
				st_bits++;
				if (st_bits == 8) begin
					st_bits = 0;
					if (cfg_dir == DIR_EXTRACT) begin
						r.byte_out = st_shift[7:0];
						r.byte_valid = 1'b1;
					end
					st_bytes++;
					if (st_bytes == st_len)
						st_phase = PH_DONE;
				end
			end
			default: ;
			endcase
			repl[n - 1 - i] = b;
		end
		r.pixel_out = (cfg_dir == DIR_EXTRACT) ? pix : ((pix & ~lowmask) | repl);
		r.done_res = (st_phase == PH_DONE);
		r.error = (st_phase == PH_DONE) && (st_len == 0);
		return r;
	endfunction

	function automatic res_t plain_result(logic [7:0] p, logic d, logic e);
		res_t r;
		r = '0;
		r.pixel_out = p;
		r.done_res = d;
		r.error = e;
		return r;
	endfunction

	function automatic step_row_t reg_row(logic [1:0] idx, logic [31:0] v);
		step_row_t r;
		r = '0;
		r.is_cfg = 1'b1;
		r.idx = idx;
		r.val = v;
		return r;
	endfunction

	function automatic step_row_t pixel_row(logic [7:0] p, logic [7:0] m, logic fs);
		step_row_t r;
		r = '0;
		r.pix = p;
		r.msg = m;
		r.fs = fs;
		return r;
	endfunction

	function automatic step_row_t pixel_row_known(logic [7:0] p, logic [7:0] m, logic fs,
			res_t e);
		step_row_t r;
		r = pixel_row(p, m, fs);
		r.typed = 1'b1;
		r.exp = e;
		return r;
	endfunction

	function automatic void compare_field(string name, logic [31:0] want, logic [31:0] got);
		if (want !== got) begin
			mismatches++;
			if (mismatches <= 10)
				$display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
		end
	endfunction

	function automatic void check_result(res_t want);
		compare_field("pixel_out", 32'(want.pixel_out), 32'(pixel_out));
		compare_field("byte_taken", 32'(want.byte_taken), 32'(byte_taken));
		compare_field("byte_out", 32'(want.byte_out), 32'(byte_out));
		compare_field("byte_valid", 32'(want.byte_valid), 32'(byte_valid));
		compare_field("length_out", want.length_out, length_out);
		compare_field("length_valid", 32'(want.length_valid), 32'(length_valid));
		compare_field("done_res", 32'(want.done_res), 32'(done_res));
		compare_field("error", 32'(want.error), 32'(error));
	endfunction

	task automatic cfg_write(logic [1:0] idx, logic [31:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		case (idx)
		REG_BITS_MODE:  cfg_mode = val[1:0];
		REG_DIRECTION:  cfg_dir = val[0];
		REG_MSG_LENGTH: cfg_len = val;
		default: ;
		endcase
	endtask

	task automatic wait_idle();
		in_valid <= 1'b0;
		while (pending.size() != 0)
			@(posedge clk);
	endtask

	task automatic send_pixel(logic [7:0] pix, logic [7:0] msg, logic fs, logic typed,
			res_t want);
		res_t pred;
		cfg_we <= 1'b0;
		while (!(items_sent >= 400 && items_sent < 520) && $urandom_range(99) < 37) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		pixel_in <= pix;
		msg_byte <= msg;
		frame_start <= fs;
		do
			@(posedge clk);
		while (!in_ready);
		pred = stego_predict(pix, msg, fs);
		pending.push_back(typed ? want : pred);
		items_sent++;
		lengths_seen += pred.length_valid;
		bytes_recovered += pred.byte_valid;
		bytes_embedded += pred.byte_taken;
		zero_flags += pred.error;
	endtask

	task automatic run_frame();
		bit          stream[$];
		logic [31:0] hdr_len;
		logic [31:0] new_len;
		logic [7:0]  pix;
		logic        fresh;
		logic        do_mode;
		logic        do_dir;
		logic        do_len;
		int unsigned n;
		int unsigned count;
		fresh = ($urandom_range(3) != 0);
		do_mode = ($urandom_range(1) != 0);
		do_dir = ($urandom_range(1) != 0);
		do_len = ($urandom_range(1) != 0);
		case ($urandom_range(9))
		0:       new_len = '0;
		1:       new_len = '1;
		2:       new_len = $urandom;
		default: new_len = $urandom_range(5, 1);
		endcase
		if (do_mode || do_dir || do_len) begin
			wait_idle();
			if (do_mode)
				cfg_write(REG_BITS_MODE, 32'($urandom_range(3)));
			if (do_dir)
				cfg_write(REG_DIRECTION,
					32'(($urandom_range(1) != 0) ? DIR_EXTRACT : DIR_EMBED));
			if (do_len)
				cfg_write(REG_MSG_LENGTH, new_len);
		end
		n = (cfg_mode == BM_ONE) ? 1 : (cfg_mode == BM_TWO) ? 2 : 4;
		if (fresh)
			frames++;
		if (fresh && cfg_dir == DIR_EXTRACT && $urandom_range(4) != 0) begin
			hdr_len = ($urandom_range(5) == 0) ? 32'd0 : 32'($urandom_range(5, 1));
			for (int b = 31; b >= 0; b--)
				stream.push_back(hdr_len[b]);
			for (int k = 0; k < 8 * hdr_len; k++)
				stream.push_back(bit'($urandom_range(1)));
			count = stream.size() / n + $urandom_range(3);
		end else if (fresh && cfg_dir == DIR_EMBED && cfg_len <= 5) begin
			count = (32 + 8 * cfg_len) / n + $urandom_range(3);
		end else begin
			count = $urandom_range(24, 2);
		end
		for (int k = 0; k < count; k++) begin
			pix = 8'($urandom);
			for (int i = 0; i < n; i++)
				if (stream.size() != 0)
					pix[n - 1 - i] = stream.pop_front();
			send_pixel(pix, 8'($urandom), (k == 0 && fresh) || $urandom_range(63) == 0,
				1'b0, '0);
		end
	endtask

	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (pending.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("%0t: result arrived with no request waiting for it", $time);
				end else begin
					check_result(pending.pop_front());
				end
				results_seen++;
			end
			out_ready <= (results_seen >= 400 && results_seen < 520) || $urandom_range(99) >= 37;
		end
	end

	initial begin
		int directed;
		dir_tab = '{
			reg_row(REG_MSG_LENGTH, 32'd1),
			pixel_row_known(8'hFF, 8'h00, 1'b1, plain_result(8'hFE, 1'b0, 1'b0)),
			reg_row(REG_BITS_MODE, 32'(BM_RSVD)),
			pixel_row(8'h00, 8'h00, 1'b0),
			pixel_row(8'hFF, 8'hFF, 1'b0),
			pixel_row(8'hA5, 8'h5A, 1'b0),
			pixel_row(8'h5A, 8'hA5, 1'b0),
			pixel_row(8'h3C, 8'h00, 1'b0),
			pixel_row(8'hC3, 8'h11, 1'b0),
			pixel_row(8'h0F, 8'h22, 1'b0),
			pixel_row(8'hF0, 8'hFF, 1'b0),
			pixel_row(8'h96, 8'h00, 1'b0),
			pixel_row(8'h69, 8'h7E, 1'b0),
			reg_row(REG_DIRECTION, 32'(DIR_EXTRACT)),
			reg_row(REG_BITS_MODE, 32'(BM_FOUR)),
			pixel_row(8'hF0, 8'hFF, 1'b1),
			pixel_row(8'h30, 8'h00, 1'b0),
			pixel_row(8'hA0, 8'h81, 1'b0),
			pixel_row(8'h50, 8'h42, 1'b0),
			reg_row(REG_DIRECTION, 32'(DIR_EMBED)),
			pixel_row(8'hFF, 8'h18, 1'b0),
			pixel_row(8'hFF, 8'hE7, 1'b0),
			pixel_row(8'h0F, 8'h00, 1'b0),
			pixel_row_known(8'hFF, 8'hFF, 1'b0, plain_result(8'hF0, 1'b1, 1'b1)),
			reg_row(REG_DIRECTION, 32'(DIR_EXTRACT)),
			pixel_row(8'h0F, 8'h00, 1'b1),
			pixel_row(8'h1F, 8'h00, 1'b0),
			pixel_row(8'h2F, 8'h00, 1'b0),
			pixel_row(8'h4F, 8'h00, 1'b0),
			pixel_row(8'h8F, 8'h00, 1'b0),
			pixel_row(8'hCF, 8'h00, 1'b0),
			pixel_row(8'hEF, 8'h00, 1'b0),
			pixel_row_known(8'hFF, 8'h00, 1'b0,
				'{8'hFF, 1'b0, 8'h00, 1'b0, 32'hFFFF_FFFF, 1'b1, 1'b0, 1'b0})
		};
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (dir_tab[k]) begin
			if (dir_tab[k].is_cfg) begin
				if (k == 0 || !dir_tab[k - 1].is_cfg)
					wait_idle();
				cfg_write(dir_tab[k].idx, dir_tab[k].val);
			end else begin
				send_pixel(dir_tab[k].pix, dir_tab[k].msg, dir_tab[k].fs, dir_tab[k].typed,
					dir_tab[k].exp);
			end
		end
		directed = items_sent;
		while (items_sent - directed < 800)
			run_frame();
		wait_idle();
		cfg_we <= 1'b0;
		repeat (4) @(posedge clk);
		$display("Sent %0d pixel requests (%0d directed) over %0d random frames; %0d results checked.",
			items_sent, directed, frames, results_seen);
		$display("Embedded %0d bytes, recovered %0d lengths and %0d bytes, %0d zero-length flags.",
			bytes_embedded, lengths_seen, bytes_recovered, zero_flags);
		if (mismatches == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

	initial begin
		#2000000;
		$display("Timeout with %0d results still outstanding.", pending.size());
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

`default_nettype wire

FILE: filelist.f
hdl/lsbse_pkg.sv
hdl/lsbse_cfg.sv
hdl/lsbse_step.sv
hdl/lsb_stego_embed_extract.sv
hdl/lsbse_checker.sv
dv/lsb_stego_embed_extract_tb.sv
